### hw/rtl/rbcr_pkg.sv
// Package for the rotated box corner restore block.
// Holds the fixed-point widths, CORDIC constants and the arctangent table.
// No dependencies.
package rbcr_pkg;

  localparam int GRID_SIZE     = 1024;
  localparam int ANCHOR_SHIFT  = 8;       // times 4, then Q.6
  localparam int ANGLE_MAX     = 25736;   // pi/2 in Q2.14
  localparam int CORDIC_STAGES = 16;
  localparam int CORDIC_X0     = 39797;   // 1/gain in Q1.16
  localparam int OUT_W         = 20;
  localparam int NUM_STAGES    = CORDIC_STAGES + 4;

  localparam logic [9:0] GRID_MAX = 10'(GRID_SIZE - 1);

  // Payload that travels through the input register and the CORDIC stages.
  typedef struct packed {
    logic [9:0]         col;
    logic [9:0]         row;
    logic [3:0][15:0]   dists;  // top, right, bottom, left
    logic               neg;
    logic [15:0]        score;
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [18:0] z;
  } cordic_t;

  // atan(2^-i) in Q2.16, rounded.
  function automatic logic signed [18:0] atan_q16(input int i);
    logic signed [18:0] t;
    case (i)
      0:       t = 19'sd51472;
      1:       t = 19'sd30386;
      2:       t = 19'sd16055;
      3:       t = 19'sd8150;
      4:       t = 19'sd4091;
      5:       t = 19'sd2047;
      6:       t = 19'sd1024;
      7:       t = 19'sd512;
      8:       t = 19'sd256;
      9:       t = 19'sd128;
      10:      t = 19'sd64;
      11:      t = 19'sd32;
      12:      t = 19'sd16;
      13:      t = 19'sd8;
      14:      t = 19'sd4;
      15:      t = 19'sd2;
      default: t = 19'sd0;
    endcase
    return t;
  endfunction

endpackage

### hw/rtl/rotated_box_corner_restore_top.sv
// Rotated box corner restore: one score-map pixel in, four rotated corners out.
// The rate of one request per clock, unless an output stall holds the pipeline, is set by
// the pipelined CORDIC, one rotation step per stage.
// Depends on rbcr_pkg.
module rotated_box_corner_restore_top
  import rbcr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [9:0]              grid_col_i,
  input  logic [9:0]              grid_row_i,
  input  logic [15:0]             dist_top_i,
  input  logic [15:0]             dist_right_i,
  input  logic [15:0]             dist_bottom_i,
  input  logic [15:0]             dist_left_i,
  input  logic signed [15:0]      angle_i,
  input  logic [15:0]             score_in_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] corner0_x_o,
  output logic signed [OUT_W-1:0] corner0_y_o,
  output logic signed [OUT_W-1:0] corner1_x_o,
  output logic signed [OUT_W-1:0] corner1_y_o,
  output logic signed [OUT_W-1:0] corner2_x_o,
  output logic signed [OUT_W-1:0] corner2_y_o,
  output logic signed [OUT_W-1:0] corner3_x_o,
  output logic signed [OUT_W-1:0] corner3_y_o,
  output logic [15:0]             score_out_o
);

  localparam int MulIdx = CORDIC_STAGES + 1;
  localparam int RndIdx = CORDIC_STAGES + 2;
  localparam int OutIdx = CORDIC_STAGES + 3;

  localparam logic signed [23:0] OutMax = 24'sd524287;
  localparam logic signed [23:0] OutMin = -24'sd524288;

  // Per-stage valid bits and load enables. A stage loads when it is empty or
  // when its contents move on, so bubbles are squeezed out under a stall.
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[OutIdx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Input stage: angle magnitude, clamping and CORDIC seed.
  cordic_t            stg_q [CORDIC_STAGES+1];
  cordic_t            stg_d [CORDIC_STAGES+1];
  logic signed [16:0] ang_ext;
  logic [16:0]        mag_full;
  logic [14:0]        mag;

  always_comb begin
    ang_ext  = 17'(angle_i);
    mag_full = angle_i[15] ? 17'(-ang_ext) : 17'(ang_ext);
    mag      = (mag_full > 17'(ANGLE_MAX)) ? 15'(ANGLE_MAX) : mag_full[14:0];

    stg_d[0].col      = (grid_col_i > GRID_MAX) ? GRID_MAX : grid_col_i;
    stg_d[0].row      = (grid_row_i > GRID_MAX) ? GRID_MAX : grid_row_i;
    stg_d[0].dists[0] = dist_top_i;
    stg_d[0].dists[1] = dist_right_i;
    stg_d[0].dists[2] = dist_bottom_i;
    stg_d[0].dists[3] = dist_left_i;
    stg_d[0].neg      = angle_i[15];
    stg_d[0].score    = score_in_i;
    stg_d[0].x        = 20'(CORDIC_X0);
    stg_d[0].y        = '0;
    stg_d[0].z        = $signed({2'b00, mag, 2'b00});

    // One rotation step per stage. Arithmetic shifts round toward minus infinity.
    for (int k = 1; k <= CORDIC_STAGES; k++) begin
      stg_d[k] = stg_q[k-1];
      if (!stg_q[k-1].z[18]) begin
        stg_d[k].x = stg_q[k-1].x - (stg_q[k-1].y >>> (k - 1));
        stg_d[k].y = stg_q[k-1].y + (stg_q[k-1].x >>> (k - 1));
        stg_d[k].z = stg_q[k-1].z - atan_q16(k - 1);
      end else begin
        stg_d[k].x = stg_q[k-1].x + (stg_q[k-1].y >>> (k - 1));
        stg_d[k].y = stg_q[k-1].y - (stg_q[k-1].x >>> (k - 1));
        stg_d[k].z = stg_q[k-1].z + atan_q16(k - 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= CORDIC_STAGES; k++) begin
      if (en[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  // Multiply stage: each distance times cosine and times signed sine.
  cordic_t            cq;
  logic signed [19:0] cos_v;
  logic signed [19:0] sin_v;
  logic signed [36:0] pc_d [4];
  logic signed [36:0] ps_d [4];
  logic signed [36:0] pc_q [4];
  logic signed [36:0] ps_q [4];
  logic [9:0]         mul_col_q, mul_row_q;
  logic [15:0]        mul_score_q;

  assign cq    = stg_q[CORDIC_STAGES];
  assign cos_v = cq.x;
  assign sin_v = cq.neg ? -cq.y : cq.y;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pc_d[k] = $signed({1'b0, cq.dists[k]}) * cos_v;
      ps_d[k] = $signed({1'b0, cq.dists[k]}) * sin_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[MulIdx]) begin
      pc_q        <= pc_d;
      ps_q        <= ps_d;
      mul_col_q   <= cq.col;
      mul_row_q   <= cq.row;
      mul_score_q <= cq.score;
    end
  end

  // Sum and round stage: corner offsets in Q.6, rounded half up.
  logic signed [37:0] sx [4];
  logic signed [37:0] sy [4];
  logic signed [37:0] wx [4];
  logic signed [37:0] wy [4];
  logic signed [21:0] rx_d [4];
  logic signed [21:0] ry_d [4];
  logic signed [21:0] rx_q [4];
  logic signed [21:0] ry_q [4];
  logic [9:0]         rnd_col_q, rnd_row_q;
  logic [15:0]        rnd_score_q;

  always_comb begin
    sx[0] = -38'(pc_q[3]) - 38'(ps_q[0]);
    sy[0] = -38'(pc_q[0]) + 38'(ps_q[3]);
    sx[1] =  38'(pc_q[1]) - 38'(ps_q[0]);
    sy[1] = -38'(pc_q[0]) - 38'(ps_q[1]);
    sx[2] =  38'(pc_q[1]) + 38'(ps_q[2]);
    sy[2] =  38'(pc_q[2]) - 38'(ps_q[1]);
    sx[3] = -38'(pc_q[3]) + 38'(ps_q[2]);
    sy[3] =  38'(pc_q[2]) + 38'(ps_q[3]);
    for (int k = 0; k < 4; k++) begin
      wx[k]   = sx[k] + 38'sd32768;
      wy[k]   = sy[k] + 38'sd32768;
      rx_d[k] = wx[k][37:16];
      ry_d[k] = wy[k][37:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[RndIdx]) begin
      rx_q        <= rx_d;
      ry_q        <= ry_d;
      rnd_col_q   <= mul_col_q;
      rnd_row_q   <= mul_row_q;
      rnd_score_q <= mul_score_q;
    end
  end

  // Output stage: add the anchor and saturate.
  logic signed [23:0]      ax, ay;
  logic signed [23:0]      cx [4];
  logic signed [23:0]      cy [4];
  logic signed [OUT_W-1:0] ox_d [4];
  logic signed [OUT_W-1:0] oy_d [4];
  logic signed [OUT_W-1:0] ox_q [4];
  logic signed [OUT_W-1:0] oy_q [4];
  logic [15:0]             score_q;

  always_comb begin
    ax = $signed(24'({rnd_col_q, ANCHOR_SHIFT'(0)}));
    ay = $signed(24'({rnd_row_q, ANCHOR_SHIFT'(0)}));
    for (int k = 0; k < 4; k++) begin
      cx[k] = ax + 24'(rx_q[k]);
      cy[k] = ay + 24'(ry_q[k]);
      if (cx[k] > OutMax) begin
        ox_d[k] = OutMax[OUT_W-1:0];
      end else if (cx[k] < OutMin) begin
        ox_d[k] = OutMin[OUT_W-1:0];
      end else begin
        ox_d[k] = cx[k][OUT_W-1:0];
      end
      if (cy[k] > OutMax) begin
        oy_d[k] = OutMax[OUT_W-1:0];
      end else if (cy[k] < OutMin) begin
        oy_d[k] = OutMin[OUT_W-1:0];
      end else begin
        oy_d[k] = cy[k][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OutIdx]) begin
      ox_q    <= ox_d;
      oy_q    <= oy_d;
      score_q <= rnd_score_q;
    end
  end

  assign corner0_x_o = ox_q[0];
  assign corner0_y_o = oy_q[0];
  assign corner1_x_o = ox_q[1];
  assign corner1_y_o = oy_q[1];
  assign corner2_x_o = ox_q[2];
  assign corner2_y_o = oy_q[2];
  assign corner3_x_o = ox_q[3];
  assign corner3_y_o = oy_q[3];
  assign score_out_o = score_q;

endmodule
